/* rtl/rctmr_pkg.sv */
// Shared types, constants and codes for the three-channel root counter timers.
package rctmr_pkg;

    localparam int NumTimers   = 3;
    localparam int CountW      = 16;
    localparam int ModeW       = 13;
    localparam int CyclesW     = 16;

    localparam int DotDiv      = 7;
    localparam int DotRestW    = 3;
    localparam int DotSumW     = CyclesW + 1;
    localparam int DotRecipW   = 18;
    localparam int DotShift    = 20;
    localparam int DotRecip    = 149797;  // ceil(2^20 / 7), exact for sums below 2^17
    localparam int DotProdW    = DotSumW + DotRecipW;
    localparam int DotQuotW    = 14;

    localparam int LineCycles  = 564480;
    localparam int LineLines   = 263;
    localparam int LineAccW    = 20;
    localparam int LineSumW    = 25;
    localparam int LineQuotW   = 5;
    localparam int LineLowW    = 8;       // 564480 = 2205 * 2^8
    localparam int LineHighW   = LineSumW - LineLowW;
    localparam int LineRecipW  = 17;
    localparam int LineShift   = 28;
    localparam int LineRecip   = 121740;  // ceil(2^28 / 2205), exact for values below 2^17
    localparam int LineProdW   = LineHighW + LineRecipW;

    localparam int EighthRestW = 3;
    localparam int EighthSumW  = CyclesW + 1;
    localparam int EighthQuotW = EighthSumW - EighthRestW;

    localparam logic [ModeW-1:0] ModeReset     = 13'h0400;
    localparam logic [9:0]       ModeWriteMask = 10'h3FF;

    localparam int BitResetOnTarget = 3;
    localparam int BitIrqOnTarget   = 4;
    localparam int BitIrqOnOverflow = 5;
    localparam int BitRepeat        = 6;
    localparam int BitRequestIdle   = 10;
    localparam int BitHitTarget     = 11;
    localparam int BitHitOverflow   = 12;

    localparam logic [1:0] SrcDot    = 2'b01;
    localparam logic [1:0] SrcLine   = 2'b01;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_ADVANCE = 2'd2,
        KIND_IGNORED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SLOT_COUNT  = 2'd0,
        SLOT_MODE   = 2'd1,
        SLOT_TARGET = 2'd2,
        SLOT_UNUSED = 2'd3
    } t_slot;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         reg_offset;
        logic [15:0]        write_data;
        logic [CyclesW-1:0] cycle_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0]          read_data;
        logic [NumTimers-1:0] irq_pulse_mask;
    } t_out_item;

    typedef struct packed {
        logic  rd;
        logic  wr;
        logic  adv;
        t_slot slot;
    } t_chan_cmd;

    typedef logic [NumTimers-1:0][CountW-1:0] t_ticks;
    typedef logic [NumTimers-1:0][1:0]        t_srcs;

endpackage

/* rtl/rctmr_prescale.sv */
// Clock source prescalers: dot clock /7, horizontal blank fixed point, and /8.
module rctmr_prescale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic [rctmr_pkg::NumTimers-1:0] i_clr,
    input  rctmr_pkg::t_srcs               i_src,
    input  logic [rctmr_pkg::CyclesW-1:0]  i_cycles,
    output rctmr_pkg::t_ticks              o_ticks
);
    import rctmr_pkg::*;

    logic [DotRestW-1:0]    r_dot_rest,    n_dot_rest;
    logic [LineAccW-1:0]    r_line_acc,    n_line_acc;
    logic [EighthRestW-1:0] r_eighth_rest, n_eighth_rest;

    logic [DotSumW-1:0]     dot_sum;
    logic [DotProdW-1:0]    dot_prod;
    logic [DotQuotW-1:0]    dot_quot;
    logic [DotSumW-1:0]     dot_times7;
    logic [DotSumW-1:0]     dot_rem;

    logic [LineSumW-1:0]    line_sum;
    logic [LineHighW-1:0]   line_high;
    logic [LineProdW-1:0]   line_prod;
    logic [LineSumW-1:0]    line_rem;
    logic [LineQuotW-1:0]   line_quot;

    logic [EighthSumW-1:0]  eighth_sum;

    logic use_dot, use_line, use_eighth;

    assign use_dot    = (i_src[0] == SrcDot);
    assign use_line   = (i_src[1] == SrcLine);
    assign use_eighth = i_src[2][1];

    // dot clock: divide by 7 through a reciprocal multiply
    always_comb begin
        dot_sum    = DotSumW'(i_cycles) + DotSumW'(r_dot_rest);
        dot_prod   = DotProdW'(dot_sum) * DotProdW'(DotRecip);
        dot_quot   = dot_prod[DotShift +: DotQuotW];
        dot_times7 = (DotSumW'(dot_quot) << 3) - DotSumW'(dot_quot);
        dot_rem    = dot_sum - dot_times7;
    end

    // horizontal blank: acc + cycles*263, then divide by 564480 through a reciprocal multiply
    always_comb begin
        line_sum  = LineSumW'(r_line_acc) + (LineSumW'(i_cycles) << 8)
                  + (LineSumW'(i_cycles) << 3) - LineSumW'(i_cycles);
        line_high = line_sum[LineSumW-1:LineLowW];
        line_prod = LineProdW'(line_high) * LineProdW'(LineRecip);
        line_quot = line_prod[LineShift +: LineQuotW];
        line_rem  = line_sum - LineSumW'(line_quot) * LineSumW'(LineCycles);
    end

    assign eighth_sum = EighthSumW'(i_cycles) + EighthSumW'(r_eighth_rest);

    always_comb begin
        o_ticks[0] = use_dot    ? CountW'(dot_quot)   : i_cycles;
        o_ticks[1] = use_line   ? CountW'(line_quot)  : i_cycles;
        o_ticks[2] = use_eighth ? CountW'(eighth_sum[EighthSumW-1:EighthRestW]) : i_cycles;
    end

    always_comb begin
        n_dot_rest    = r_dot_rest;
        n_line_acc    = r_line_acc;
        n_eighth_rest = r_eighth_rest;
        if (i_clr[0]) begin
            n_dot_rest = '0;
        end else if (i_adv && use_dot) begin
            n_dot_rest = dot_rem[DotRestW-1:0];
        end
        if (i_clr[1]) begin
            n_line_acc = '0;
        end else if (i_adv && use_line) begin
            n_line_acc = line_rem[LineAccW-1:0];
        end
        if (i_clr[2]) begin
            n_eighth_rest = '0;
        end else if (i_adv && use_eighth) begin
            n_eighth_rest = eighth_sum[EighthRestW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_rest    <= '0;
            r_line_acc    <= '0;
            r_eighth_rest <= '0;
        end else begin
            r_dot_rest    <= n_dot_rest;
            r_line_acc    <= n_line_acc;
            r_eighth_rest <= n_eighth_rest;
        end
    end

endmodule

/* rtl/rctmr_channel.sv */
// One timer channel: counter, target, mode register and one-shot latch.
module rctmr_channel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rctmr_pkg::t_chan_cmd          i_cmd,
    input  logic [15:0]                   i_data,
    input  logic [rctmr_pkg::CountW-1:0]  i_ticks,
    input  logic                          i_irq_en,
    output logic [15:0]                   o_rdata,
    output logic                          o_irq,
    output logic [1:0]                    o_src
);
    import rctmr_pkg::*;

    logic [CountW-1:0] r_count,   n_count;
    logic [CountW-1:0] r_target,  n_target;
    logic [ModeW-1:0]  r_mode,    n_mode;
    logic              r_oneshot, n_oneshot;

    logic [CountW:0]   sum;
    logic              hit_t, hit_o, want_irq, fire;

    assign o_src = r_mode[9:8];

    always_comb begin
        sum = {1'b0, r_count} + {1'b0, i_ticks};
        if (!sum[CountW]) begin
            hit_t = (r_count < r_target) && (r_target <= sum[CountW-1:0]);
        end else begin
            hit_t = (r_target > r_count) || (r_target <= sum[CountW-1:0]);
        end
        hit_o    = sum[CountW];
        want_irq = (r_mode[BitIrqOnTarget] && hit_t) || (r_mode[BitIrqOnOverflow] && hit_o);
        fire     = want_irq && i_irq_en && (r_mode[BitRepeat] || !r_oneshot);
    end

    always_comb begin
        n_count   = r_count;
        n_target  = r_target;
        n_mode    = r_mode;
        n_oneshot = r_oneshot;
        o_rdata   = '0;
        o_irq     = 1'b0;
        if (i_cmd.rd) begin
            unique case (i_cmd.slot)
                SLOT_COUNT:  o_rdata = r_count;
                SLOT_MODE: begin
                    o_rdata                = 16'(r_mode);
                    n_mode[BitHitTarget]   = 1'b0;
                    n_mode[BitHitOverflow] = 1'b0;
                    n_mode[BitRequestIdle] = 1'b1;
                end
                SLOT_TARGET: o_rdata = r_target;
                default:     o_rdata = '0;
            endcase
        end
        if (i_cmd.wr) begin
            unique case (i_cmd.slot)
                SLOT_COUNT:  n_count = i_data;
                SLOT_MODE: begin
                    n_mode    = ModeReset | ModeW'(i_data[9:0] & ModeWriteMask);
                    n_oneshot = 1'b0;
                    n_count   = '0;
                end
                SLOT_TARGET: n_target = i_data;
                default:     n_count = r_count;
            endcase
        end
        if (i_cmd.adv) begin
            n_count = (r_mode[BitResetOnTarget] && hit_t) ? '0 : sum[CountW-1:0];
            if (hit_t) begin
                n_mode[BitHitTarget] = 1'b1;
            end
            if (hit_o) begin
                n_mode[BitHitOverflow] = 1'b1;
            end
            if (fire) begin
                n_oneshot              = 1'b1;
                n_mode[BitRequestIdle] = 1'b0;
                o_irq                  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_target  <= '0;
            r_mode    <= ModeReset;
            r_oneshot <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_target  <= n_target;
            r_mode    <= n_mode;
            r_oneshot <= n_oneshot;
        end
    end

endmodule

/* rtl/three_channel_root_counter_timers.sv */
// Top level of the three-channel root counter timers.
// Each transaction is a register read, a register write, a time advance or an
// ignored kind, and yields exactly one result transaction. A transaction is
// captured in an input register and is executed by combinational logic into the
// output register, so one transaction is taken every cycle when the result side
// keeps up. The longest path is the horizontal blank prescaler (a shift by 8 and a
// reciprocal multiply for the divide by 2205) feeding the counter add and target
// compare. Timer 0 can divide its clock by 7, timer 1 count horizontal blanks in
// exact fixed point and timer 2 divide by 8.
// Configuration writes are taken at any time and should occur only while idle.
module three_channel_root_counter_timers (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rctmr_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rctmr_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data
);
    import rctmr_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out, n_out;
    logic      r_irq_en;

    logic      go;
    t_kind     kind;
    t_slot     slot;
    logic [1:0] timer_sel;
    logic [NumTimers-1:0] sel;
    logic [NumTimers-1:0] mode_clr;
    logic [NumTimers-1:0] irq;
    logic [NumTimers-1:0][15:0] rdata;
    t_chan_cmd [NumTimers-1:0]  cmd;
    t_ticks    ticks;
    t_srcs     srcs;
    logic      do_rd, do_wr, do_adv;

    assign go         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || go;

    assign kind      = t_kind'(r_in.mode);
    assign slot      = t_slot'(r_in.reg_offset[3:2]);
    assign timer_sel = r_in.reg_offset[5:4];

    always_comb begin
        do_rd  = 1'b0;
        do_wr  = 1'b0;
        do_adv = 1'b0;
        unique case (kind)
            KIND_READ:    do_rd  = go;
            KIND_WRITE:   do_wr  = go;
            KIND_ADVANCE: do_adv = go;
            default:      do_rd  = 1'b0;
        endcase
    end

    always_comb begin
        for (int t = 0; t < NumTimers; t++) begin
            sel[t]         = (timer_sel == 2'(t));
            cmd[t].rd      = do_rd && sel[t];
            cmd[t].wr      = do_wr && sel[t];
            cmd[t].adv     = do_adv;
            cmd[t].slot    = slot;
            mode_clr[t]    = do_wr && sel[t] && (slot == SLOT_MODE);
        end
    end

    rctmr_prescale u_prescale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (do_adv),
        .i_clr    (mode_clr),
        .i_src    (srcs),
        .i_cycles (r_in.cycle_count),
        .o_ticks  (ticks)
    );

    for (genvar g = 0; g < NumTimers; g++) begin : g_chan
        rctmr_channel u_chan (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd[g]),
            .i_data   (r_in.write_data),
            .i_ticks  (ticks[g]),
            .i_irq_en (r_irq_en),
            .o_rdata  (rdata[g]),
            .o_irq    (irq[g]),
            .o_src    (srcs[g])
        );
    end

    always_comb begin
        n_out.read_data      = rdata[0] | rdata[1] | rdata[2];
        n_out.irq_pulse_mask = irq;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_irq_en    <= 1'b1;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_irq_en <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (go) begin
            r_out <= n_out;
        end
    end

endmodule

/* tb/sv/three_channel_root_counter_timers_checker.sv */
// Transaction checker that predicts and compares the results of the root counter timers.
module three_channel_root_counter_timers_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  rctmr_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  rctmr_pkg::t_out_item i_out_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rctmr_pkg::*;

    localparam int ReportLimit = 10;

    logic [CountW-1:0]      count_q  [NumTimers];
    logic [CountW-1:0]      target_q [NumTimers];
    logic [ModeW-1:0]       mode_q   [NumTimers];
    logic                   fired_q  [NumTimers];
    logic [DotRestW-1:0]    dot_rest;
    logic [LineAccW-1:0]    line_acc;
    logic [EighthRestW-1:0] eighth_rest;
    logic                   sink_on;

    t_out_item expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int unsigned source_ticks(input int t, input int unsigned cycles);
        int unsigned acc;
        logic [1:0]  src;
        src = mode_q[t][9:8];
        if (t == 1 && src == SrcLine) begin
            acc      = line_acc + cycles * LineLines;
            line_acc = LineAccW'(acc % LineCycles);
            return acc / LineCycles;
        end
        if (t == 2 && src[1]) begin
            acc         = eighth_rest + cycles;
            eighth_rest = acc[EighthRestW-1:0];
            return acc >> EighthRestW;
        end
        if (t == 0 && src == SrcDot) begin
            acc      = dot_rest + cycles;
            dot_rest = DotRestW'(acc % DotDiv);
            return acc / DotDiv;
        end
        return cycles;
    endfunction

    function automatic logic advance_timer(input int t, input int unsigned cycles);
        int unsigned n;
        int unsigned prev;
        int unsigned sum;
        int unsigned nxt;
        int unsigned tgt;
        logic        hit_t;
        logic        hit_o;
        logic        irq;
        n = source_ticks(t, cycles);
        if (n == 0)
            return 1'b0;
        prev = count_q[t];
        tgt  = target_q[t];
        sum  = prev + n;
        nxt  = sum & 32'hFFFF;
        if (sum <= 32'hFFFF)
            hit_t = (prev < tgt) && (tgt <= sum);
        else
            hit_t = (tgt > prev) || (tgt <= nxt);
        hit_o = nxt < prev;
        count_q[t] = nxt[CountW-1:0];
        if (hit_t)
            mode_q[t][BitHitTarget] = 1'b1;
        if (hit_o)
            mode_q[t][BitHitOverflow] = 1'b1;
        if (mode_q[t][BitResetOnTarget] && hit_t)
            count_q[t] = '0;
        irq = (mode_q[t][BitIrqOnTarget] && hit_t) || (mode_q[t][BitIrqOnOverflow] && hit_o);
        if (!irq || !sink_on)
            return 1'b0;
        if (!mode_q[t][BitRepeat] && fired_q[t])
            return 1'b0;
        fired_q[t]                = 1'b1;
        mode_q[t][BitRequestIdle] = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_out_item timer_result(input t_in_item item);
        t_out_item res;
        int        t;
        t_slot     slot;
        res  = '0;
        t    = item.reg_offset[5:4];
        slot = t_slot'(item.reg_offset[3:2]);
        case (t_kind'(item.mode))
            KIND_READ: begin
                if (t < NumTimers) begin
                    case (slot)
                        SLOT_COUNT:  res.read_data = count_q[t];
                        SLOT_MODE: begin
                            res.read_data                = 16'(mode_q[t]);
                            mode_q[t][BitHitTarget]      = 1'b0;
                            mode_q[t][BitHitOverflow]    = 1'b0;
                            mode_q[t][BitRequestIdle]    = 1'b1;
                        end
                        SLOT_TARGET: res.read_data = target_q[t];
                        default: ;
                    endcase
                end
            end
            KIND_WRITE: begin
                if (t < NumTimers) begin
                    case (slot)
                        SLOT_COUNT:  count_q[t] = item.write_data;
                        SLOT_MODE: begin
                            mode_q[t]  = ModeReset | ModeW'(item.write_data[9:0] & ModeWriteMask);
                            fired_q[t] = 1'b0;
                            count_q[t] = '0;
                            case (t)
                                0:       dot_rest    = '0;
                                1:       line_acc    = '0;
                                default: eighth_rest = '0;
                            endcase
                        end
                        SLOT_TARGET: target_q[t] = item.write_data;
                        default: ;
                    endcase
                end
            end
            KIND_ADVANCE: begin
                for (int i = 0; i < NumTimers; i++)
                    res.irq_pulse_mask[i] = advance_timer(i, item.cycle_count);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= ReportLimit)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < NumTimers; i++) begin
                count_q[i]  = '0;
                target_q[i] = '0;
                mode_q[i]   = ModeReset;
                fired_q[i]  = 1'b0;
            end
            dot_rest    = '0;
            line_acc    = '0;
            eighth_rest = '0;
            sink_on     = 1'b1;
            expected_results.delete();
        end else begin
            if (i_cfg_we)
                sink_on = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: read_data %h irq %b",
                                           i_out_item.read_data, i_out_item.irq_pulse_mask));
                end else begin
                    want = expected_results.pop_front();
                    if (want.read_data !== i_out_item.read_data ||
                        want.irq_pulse_mask !== i_out_item.irq_pulse_mask)
                        note_failure($sformatf(
                            "mismatch: expected read_data %h irq %b, got read_data %h irq %b",
                            want.read_data, want.irq_pulse_mask,
                            i_out_item.read_data, i_out_item.irq_pulse_mask));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(timer_result(i_in_item));
        end
        o_pending = expected_results.size();
    end

endmodule

/* tb/sv/three_channel_root_counter_timers_tb.sv */
// Top of the root counter timers testbench: clock, reset, stimulus and verdict.
module three_channel_root_counter_timers_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rctmr_pkg::*;

    localparam int LongHoldCycles = 150;
    localparam int CycleLimit     = 400000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    logic      cfg_we;
    logic      cfg_data;
    int        fail_count;
    int        pending;
    int        cycle_n;
    bit        hold_req;
    bit        idle_off;

    three_channel_root_counter_timers i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    three_channel_root_counter_timers_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial cycle_n = 0;
    always @(posedge clk) begin
        cycle_n++;
        if (cycle_n > CycleLimit) begin
            $display("three_channel_root_counter_timers test failed");
            $finish;
        end
    end

    function automatic logic [5:0] reg_addr(input int timer, input t_slot slot,
                                            input int lane = 0);
        return {2'(timer), slot, 2'(lane)};
    endfunction

    function automatic t_in_item mk(input t_kind kind, input logic [5:0] offset,
                                    input logic [15:0] data, input logic [15:0] cycles);
        t_in_item item;
        item.mode        = kind;
        item.reg_offset  = offset;
        item.write_data  = data;
        item.cycle_count = cycles;
        return item;
    endfunction

    // call at a falling edge; returns at a falling edge with valid possibly still high
    task automatic offer_transaction(input t_in_item item);
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_irq_sink(input logic value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        t_in_item item;
        int       sel;
        int       tmr;
        t_slot    slot;
        for (int n = 0; n < count; n++) begin
            sel  = $urandom_range(0, 99);
            tmr  = $urandom_range(0, 2);
            slot = t_slot'($urandom_range(0, 2));
            item.write_data = 16'($urandom);
            item.reg_offset = reg_addr(tmr, slot, $urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: item.cycle_count = 16'($urandom_range(0, 20));
                4, 5, 6:    item.cycle_count = 16'($urandom_range(0, 2000));
                7, 8:       item.cycle_count = 16'($urandom);
                default:    item.cycle_count = 16'hFFFF;
            endcase
            if (sel < 40) begin
                item.mode = KIND_ADVANCE;
            end else if (sel < 65) begin
                item.mode = KIND_READ;
            end else if (sel < 95) begin
                item.mode = KIND_WRITE;
                if (slot != SLOT_MODE && $urandom_range(0, 1) == 0)
                    item.write_data = 16'($urandom_range(0, 300));
            end else begin
                item.mode       = 2'($urandom_range(0, 3));
                item.reg_offset = 6'($urandom);
                if ($urandom_range(0, 1) == 0)
                    item.mode = KIND_IGNORED;
            end
            offer_transaction(item);
        end
    endtask

    initial begin : receiver
        int k;
        out_ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LongHoldCycles) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else if (!idle_off && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                k = $urandom_range(1, 3);
                repeat (k) @(negedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_data = 1'b0;
        hold_req = 1'b0;
        idle_off = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        offer_transaction(mk(KIND_READ, reg_addr(0, SLOT_MODE), 16'h0, 16'h0));
        offer_transaction(mk(KIND_WRITE, reg_addr(0, SLOT_MODE),
            16'((1 << BitIrqOnTarget) | (1 << BitIrqOnOverflow) | (1 << BitRepeat)), 16'h0));
        offer_transaction(mk(KIND_WRITE, reg_addr(0, SLOT_TARGET), 16'hFFFF, 16'h0));
        offer_transaction(mk(KIND_WRITE, reg_addr(0, SLOT_COUNT), 16'hFFFE, 16'h0));
        offer_transaction(mk(KIND_WRITE, reg_addr(1, SLOT_MODE),
            {6'h0, SrcLine, 8'h0} | 16'((1 << BitResetOnTarget) | (1 << BitIrqOnTarget)),
            16'h0));
        offer_transaction(mk(KIND_WRITE, reg_addr(1, SLOT_TARGET), 16'h0001, 16'h0));
        offer_transaction(mk(KIND_WRITE, reg_addr(2, SLOT_MODE),
            {6'h0, 2'b10, 8'h0} | 16'((1 << BitIrqOnTarget) | (1 << BitIrqOnOverflow)),
            16'h0));
        offer_transaction(mk(KIND_WRITE, reg_addr(2, SLOT_TARGET), 16'h0000, 16'h0));
        offer_transaction(mk(KIND_ADVANCE, reg_addr(0, SLOT_COUNT), 16'h0, 16'hFFFF));
        offer_transaction(mk(KIND_ADVANCE, reg_addr(0, SLOT_COUNT), 16'h0, 16'h0000));
        offer_transaction(mk(KIND_ADVANCE, reg_addr(0, SLOT_COUNT), 16'h0, 16'hFFFF));
        offer_transaction(mk(KIND_READ, reg_addr(0, SLOT_COUNT), 16'h0, 16'h0));
        offer_transaction(mk(KIND_READ, reg_addr(0, SLOT_MODE), 16'h0, 16'h0));
        offer_transaction(mk(KIND_READ, reg_addr(0, SLOT_MODE), 16'h0, 16'h0));
        offer_transaction(mk(KIND_READ, reg_addr(1, SLOT_MODE), 16'h0, 16'h0));
        offer_transaction(mk(KIND_READ, reg_addr(0, SLOT_TARGET), 16'h0, 16'h0));
        offer_transaction(mk(KIND_READ, reg_addr(0, SLOT_UNUSED), 16'h0, 16'h0));
        offer_transaction(mk(KIND_WRITE, reg_addr(1, SLOT_UNUSED), 16'hFFFF, 16'h0));
        offer_transaction(mk(KIND_READ, reg_addr(3, SLOT_COUNT), 16'h0, 16'h0));
        offer_transaction(mk(KIND_WRITE, reg_addr(3, SLOT_UNUSED, 3), 16'hFFFF, 16'hFFFF));
        offer_transaction(mk(KIND_READ, reg_addr(3, SLOT_UNUSED, 3), 16'h0, 16'h0));
        offer_transaction(mk(KIND_IGNORED, reg_addr(3, SLOT_UNUSED, 3), 16'hFFFF, 16'hFFFF));
        offer_transaction(mk(KIND_WRITE, reg_addr(0, SLOT_MODE), 16'hFDFF, 16'h0));
        offer_transaction(mk(KIND_ADVANCE, reg_addr(0, SLOT_COUNT), 16'h0, 16'd13));
        offer_transaction(mk(KIND_READ, reg_addr(2, SLOT_COUNT), 16'h0, 16'h0));

        write_irq_sink(1'b0);
        run_random(100);
        write_irq_sink(1'b1);
        hold_req = 1'b1;
        run_random(150);
        write_irq_sink(1'b0);
        run_random(60);
        write_irq_sink(1'b1);
        idle_off = 1'b1;
        run_random(170);
        drain_results();
        repeat (8) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("three_channel_root_counter_timers test passed");
        else
            $display("three_channel_root_counter_timers test failed");
        $finish;
    end

endmodule

/* three_channel_root_counter_timers.f */
rtl/rctmr_pkg.sv
rtl/rctmr_prescale.sv
rtl/rctmr_channel.sv
rtl/three_channel_root_counter_timers.sv
tb/sv/three_channel_root_counter_timers_checker.sv
tb/sv/three_channel_root_counter_timers_tb.sv
